// ===== design/ems_pkg.sv =====
// ----------------------------------------------------------------------------
// ems_pkg: shared types and constants of the external merge sorter
// Beat structs, operation and status codes, and the controller command set.
// ----------------------------------------------------------------------------
`default_nettype none

package ems_pkg;

  localparam int VALUE_WIDTH       = 32;
  localparam int STORE_DEPTH_DEF   = 1024;
  localparam int MAX_RUNS_DEF      = 64;
  localparam int CFG_W             = 11;

  localparam logic [CFG_W-1:0] RUN_MIN   = 11'd16;
  localparam logic [CFG_W-1:0] RUN_MAX   = 11'd1024;
  localparam logic [CFG_W-1:0] RUN_RESET = 11'd64;

  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_PULL    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] ST_PULLED = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;
  localparam logic [1:0] ST_DROP   = 2'd3;

  typedef struct packed {
    logic [1:0]                    operation;
    logic signed [VALUE_WIDTH-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] result_value;
    logic [1:0]                    status;
    logic                          final_value;
  } out_beat_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DISP,
    CMD_INS_I,
    CMD_INS_X,
    CMD_INS_CHK,
    CMD_INS_CMP,
    CMD_CLOSE,
    CMD_B_INIT,
    CMD_B_RUN,
    CMD_B_TAB,
    CMD_B_VAL,
    CMD_SU,
    CMD_SU_CMP,
    CMD_P_START,
    CMD_P_TOP,
    CMD_P_TAB,
    CMD_P_NEW,
    CMD_P_LAST,
    CMD_SD,
    CMD_SD_L,
    CMD_SD_R,
    CMD_SD_C,
    CMD_RESP
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e    cmd;
    logic [1:0] resp;
  } dp_ctrl_t;

  typedef struct packed {
    logic op_push;
    logic op_pull;
    logic op_restart;
    logic drop;
    logic close_now;
    logic draining;
    logic open_nonempty;
    logic i_done;
    logic j_at_open;
    logic key_lt_store;
    logic runs_done;
    logic key_lt_heap;
    logic k_zero;
    logic hsize_zero;
    logic run_more;
    logic l_in;
    logic r_in;
    logic child_lt_key;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/ems_datapath.sv =====
// ----------------------------------------------------------------------------
// ems_datapath: storage and compare logic of the merge sorter
// Value store, run table and min-heap memories with the counters and keys
// that the controller steps through, one access to each memory per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ems_datapath #(
  parameter int STORE_DEPTH = 1024,
  parameter int MAX_RUNS    = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ems_pkg::dp_ctrl_t        ctrl_i,
  output ems_pkg::dp_stat_t             stat_o,
  input  wire ems_pkg::in_beat_t        in_beat_i,
  input  wire logic                     cfg_valid_i,
  input  wire logic [ems_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                     out_stall_i,
  output logic                          out_valid_o,
  output ems_pkg::out_beat_t            out_beat_o
);
  import ems_pkg::*;

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int CW  = $clog2(STORE_DEPTH + 1);
  localparam int RW  = $clog2(MAX_RUNS);
  localparam int RCW = $clog2(MAX_RUNS + 1);
  localparam int LW  = (CW > CFG_W) ? CW : CFG_W;
  localparam int VW  = VALUE_WIDTH;
  localparam int HEW = VW + RW;
  localparam int TEW = 2 * CW;

  logic [VW-1:0]  store_mem [STORE_DEPTH];
  logic [TEW-1:0] tab_mem   [MAX_RUNS];
  logic [HEW-1:0] heap_mem  [MAX_RUNS];

  logic [1:0]           op_q;
  logic signed [VW-1:0] val_q;
  logic [CFG_W-1:0]     rl_q;
  logic [CW-1:0]        cnt_q, open_q, i_q, j_q;
  logic [RCW-1:0]       runs_q, hsize_q, r_q;
  logic                 draining_q;
  logic signed [VW-1:0] xv_q, cv_q, res_q;
  logic [RW-1:0]        xr_q, cr_q, ci_q, k_q, src_q;
  logic                 out_valid_q;
  out_beat_t            out_q;

  logic signed [VW-1:0] srd_q;
  logic [TEW-1:0]       trd_q;
  logic [HEW-1:0]       hrd_q;

  logic           s_we;
  logic [AW-1:0]  s_waddr, s_raddr;
  logic [VW-1:0]  s_wdata;
  logic           t_we;
  logic [RW-1:0]  t_waddr, t_raddr;
  logic [TEW-1:0] t_wdata;
  logic           h_we;
  logic [RW-1:0]  h_waddr, h_raddr;
  logic [HEW-1:0] h_wdata;

  logic [CFG_W-1:0]     rl_c;
  logic [LW:0]          fill;
  logic [CW-1:0]        tab_pos, tab_end;
  logic signed [VW-1:0] hrd_val;
  logic [RW-1:0]        hrd_run, k_par;
  logic [RW:0]          l_idx, r_idx, hsize_ext;
  logic                 right_lt_child;
  logic [HEW-1:0]       key_entry, child_entry;

  assign rl_c = (rl_q < RUN_MIN) ? RUN_MIN : ((rl_q > RUN_MAX) ? RUN_MAX : rl_q);
  assign fill = (LW+1)'(cnt_q) - (LW+1)'(open_q) + (LW+1)'(1);
  assign tab_pos = trd_q[TEW-1:CW];
  assign tab_end = trd_q[CW-1:0];
  assign hrd_val = hrd_q[HEW-1:RW];
  assign hrd_run = hrd_q[RW-1:0];
  assign k_par = (k_q - RW'(1)) >> 1;
  assign l_idx = {k_q, 1'b1};
  assign r_idx = l_idx + (RW+1)'(1);
  assign hsize_ext = (RW+1)'(hsize_q);
  assign right_lt_child = hrd_val < cv_q;
  assign key_entry = {xv_q, xr_q};
  assign child_entry = {cv_q, cr_q};

  assign stat_o.op_push       = op_q == OP_PUSH;
  assign stat_o.op_pull       = op_q == OP_PULL;
  assign stat_o.op_restart    = op_q == OP_RESTART;
  assign stat_o.drop          = draining_q || (cnt_q >= CW'(STORE_DEPTH))
                                || (runs_q >= RCW'(MAX_RUNS));
  assign stat_o.close_now     = fill >= (LW+1)'(rl_c);
  assign stat_o.draining      = draining_q;
  assign stat_o.open_nonempty = cnt_q > open_q;
  assign stat_o.i_done        = i_q >= cnt_q;
  assign stat_o.j_at_open     = j_q == open_q;
  assign stat_o.key_lt_store  = xv_q < srd_q;
  assign stat_o.runs_done     = r_q == runs_q;
  assign stat_o.key_lt_heap   = xv_q < hrd_val;
  assign stat_o.k_zero        = k_q == '0;
  assign stat_o.hsize_zero    = hsize_q == '0;
  assign stat_o.run_more      = tab_pos < tab_end;
  assign stat_o.l_in          = l_idx < hsize_ext;
  assign stat_o.r_in          = r_idx < hsize_ext;
  assign stat_o.child_lt_key  = cv_q < xv_q;
  assign stat_o.out_free      = !out_valid_q || !out_stall_i;

  always_comb begin
    s_we = 1'b0;
    s_waddr = '0;
    s_wdata = xv_q;
    s_raddr = '0;
    t_we = 1'b0;
    t_waddr = '0;
    t_wdata = {tab_pos + CW'(1), tab_end};
    t_raddr = '0;
    h_we = 1'b0;
    h_waddr = k_q;
    h_wdata = key_entry;
    h_raddr = '0;
    case (ctrl_i.cmd)
      CMD_DISP: begin
        if (stat_o.op_push && !stat_o.drop) begin
          s_we = 1'b1;
          s_waddr = cnt_q[AW-1:0];
          s_wdata = val_q;
        end
      end
      CMD_INS_I: s_raddr = i_q[AW-1:0];
      CMD_INS_CHK: begin
        if (stat_o.j_at_open) begin
          s_we = 1'b1;
          s_waddr = j_q[AW-1:0];
        end else begin
          s_raddr = AW'(j_q - CW'(1));
        end
      end
      CMD_INS_CMP: begin
        s_we = 1'b1;
        s_waddr = j_q[AW-1:0];
        s_wdata = stat_o.key_lt_store ? srd_q : xv_q;
      end
      CMD_CLOSE: begin
        if (runs_q < RCW'(MAX_RUNS)) begin
          t_we = 1'b1;
          t_waddr = runs_q[RW-1:0];
          t_wdata = {open_q, cnt_q};
        end
      end
      CMD_B_RUN: t_raddr = r_q[RW-1:0];
      CMD_B_TAB: begin
        s_raddr = tab_pos[AW-1:0];
        t_we = 1'b1;
        t_waddr = r_q[RW-1:0];
      end
      CMD_SU: begin
        if (stat_o.k_zero) begin
          h_we = 1'b1;
        end else begin
          h_raddr = k_par;
        end
      end
      CMD_SU_CMP: begin
        h_we = 1'b1;
        h_wdata = stat_o.key_lt_heap ? hrd_q : key_entry;
      end
      CMD_P_TOP: t_raddr = hrd_run;
      CMD_P_TAB: begin
        if (stat_o.run_more) begin
          s_raddr = tab_pos[AW-1:0];
          t_we = 1'b1;
          t_waddr = src_q;
        end else begin
          h_raddr = RW'(hsize_q - RCW'(1));
        end
      end
      CMD_SD: begin
        if (stat_o.l_in) begin
          h_raddr = l_idx[RW-1:0];
        end else begin
          h_we = 1'b1;
        end
      end
      CMD_SD_L: h_raddr = r_idx[RW-1:0];
      CMD_SD_C: begin
        h_we = 1'b1;
        h_wdata = stat_o.child_lt_key ? child_entry : key_entry;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      store_mem[s_waddr] <= s_wdata;
    end
    srd_q <= store_mem[s_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      tab_mem[t_waddr] <= t_wdata;
    end
    trd_q <= tab_mem[t_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      heap_mem[h_waddr] <= h_wdata;
    end
    hrd_q <= heap_mem[h_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rl_q <= RUN_RESET;
      cnt_q <= '0;
      open_q <= '0;
      runs_q <= '0;
      hsize_q <= '0;
      draining_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        rl_q <= cfg_data_i;
      end
      case (ctrl_i.cmd)
        CMD_DISP: begin
          if (stat_o.op_restart) begin
            cnt_q <= '0;
            open_q <= '0;
            runs_q <= '0;
            hsize_q <= '0;
            draining_q <= 1'b0;
          end
          if (stat_o.op_push && !stat_o.drop) begin
            cnt_q <= cnt_q + CW'(1);
          end
          if (stat_o.op_pull) begin
            draining_q <= 1'b1;
          end
        end
        CMD_CLOSE: begin
          if (runs_q < RCW'(MAX_RUNS)) begin
            runs_q <= runs_q + RCW'(1);
          end
          open_q <= cnt_q;
        end
        CMD_B_INIT: hsize_q <= '0;
        CMD_B_VAL:  hsize_q <= hsize_q + RCW'(1);
        CMD_P_TAB: begin
          if (!stat_o.run_more) begin
            hsize_q <= hsize_q - RCW'(1);
          end
        end
        default: ;
      endcase
      if (ctrl_i.cmd == CMD_RESP) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CMD_LOAD: begin
        op_q <= in_beat_i.operation;
        val_q <= in_beat_i.value;
      end
      CMD_DISP: i_q <= open_q + CW'(1);
      CMD_INS_X: begin
        xv_q <= srd_q;
        j_q <= i_q;
      end
      CMD_INS_CHK: begin
        if (stat_o.j_at_open) begin
          i_q <= i_q + CW'(1);
        end
      end
      CMD_INS_CMP: begin
        if (stat_o.key_lt_store) begin
          j_q <= j_q - CW'(1);
        end else begin
          i_q <= i_q + CW'(1);
        end
      end
      CMD_B_INIT: r_q <= '0;
      CMD_B_VAL: begin
        xv_q <= srd_q;
        xr_q <= r_q[RW-1:0];
        k_q <= hsize_q[RW-1:0];
      end
      CMD_SU: begin
        if (stat_o.k_zero) begin
          r_q <= r_q + RCW'(1);
        end
      end
      CMD_SU_CMP: begin
        if (stat_o.key_lt_heap) begin
          k_q <= k_par;
        end else begin
          r_q <= r_q + RCW'(1);
        end
      end
      CMD_P_TOP: begin
        res_q <= hrd_val;
        src_q <= hrd_run;
      end
      CMD_P_NEW: begin
        xv_q <= srd_q;
        xr_q <= src_q;
        k_q <= '0;
      end
      CMD_P_LAST: begin
        xv_q <= hrd_val;
        xr_q <= hrd_run;
        k_q <= '0;
      end
      CMD_SD_L: begin
        cv_q <= hrd_val;
        cr_q <= hrd_run;
        ci_q <= l_idx[RW-1:0];
      end
      CMD_SD_R: begin
        if (right_lt_child) begin
          cv_q <= hrd_val;
          cr_q <= hrd_run;
          ci_q <= r_idx[RW-1:0];
        end
      end
      CMD_SD_C: begin
        if (stat_o.child_lt_key) begin
          k_q <= ci_q;
        end
      end
      CMD_RESP: begin
        out_q.result_value <= (ctrl_i.resp == ST_PULLED) ? res_q : '0;
        out_q.status <= ctrl_i.resp;
        out_q.final_value <= (ctrl_i.resp == ST_PULLED) && (hsize_q == '0);
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) hsize_q <= runs_q)
    else $error("heap holds more heads than runs");
  assert property (@(posedge clk_i) disable iff (!rst_ni) open_q <= cnt_q)
    else $error("open run starts beyond stored count");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !draining_q |-> hsize_q == '0)
    else $error("heap loaded while still loading values");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (ctrl_i.cmd == CMD_DISP && stat_o.op_restart) |=> (cnt_q == '0 && runs_q == '0))
    else $error("restart left stored values behind");

endmodule

`default_nettype wire

// ===== design/ems_controller.sv =====
// ----------------------------------------------------------------------------
// ems_controller: sequencer of the merge sorter
// Steps run sorting, heap build, pop and sift through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ems_controller (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ems_pkg::dp_stat_t stat_i,
  output ems_pkg::dp_ctrl_t      ctrl_o
);
  import ems_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_INS_I, S_INS_X, S_INS_CHK, S_INS_CMP, S_CLOSE,
    S_B_INIT, S_B_RUN, S_B_TAB, S_B_VAL, S_SU, S_SU_CMP,
    S_P_START, S_P_TOP, S_P_TAB, S_P_NEW, S_P_LAST,
    S_SD, S_SD_L, S_SD_R, S_SD_C, S_RESP
  } state_e;

  state_e     state_q;
  logic       ret_build_q;
  logic [1:0] resp_q;

  assign in_stall_o = state_q != S_IDLE;
  assign ctrl_o.resp = resp_q;

  always_comb begin
    case (state_q)
      S_IDLE:    ctrl_o.cmd = in_valid_i ? CMD_LOAD : CMD_NONE;
      S_DISP:    ctrl_o.cmd = CMD_DISP;
      S_INS_I:   ctrl_o.cmd = CMD_INS_I;
      S_INS_X:   ctrl_o.cmd = CMD_INS_X;
      S_INS_CHK: ctrl_o.cmd = CMD_INS_CHK;
      S_INS_CMP: ctrl_o.cmd = CMD_INS_CMP;
      S_CLOSE:   ctrl_o.cmd = CMD_CLOSE;
      S_B_INIT:  ctrl_o.cmd = CMD_B_INIT;
      S_B_RUN:   ctrl_o.cmd = CMD_B_RUN;
      S_B_TAB:   ctrl_o.cmd = CMD_B_TAB;
      S_B_VAL:   ctrl_o.cmd = CMD_B_VAL;
      S_SU:      ctrl_o.cmd = CMD_SU;
      S_SU_CMP:  ctrl_o.cmd = CMD_SU_CMP;
      S_P_START: ctrl_o.cmd = CMD_P_START;
      S_P_TOP:   ctrl_o.cmd = CMD_P_TOP;
      S_P_TAB:   ctrl_o.cmd = CMD_P_TAB;
      S_P_NEW:   ctrl_o.cmd = CMD_P_NEW;
      S_P_LAST:  ctrl_o.cmd = CMD_P_LAST;
      S_SD:      ctrl_o.cmd = CMD_SD;
      S_SD_L:    ctrl_o.cmd = CMD_SD_L;
      S_SD_R:    ctrl_o.cmd = CMD_SD_R;
      S_SD_C:    ctrl_o.cmd = CMD_SD_C;
      S_RESP:    ctrl_o.cmd = stat_i.out_free ? CMD_RESP : CMD_NONE;
      default:   ctrl_o.cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_build_q <= 1'b0;
      resp_q <= ST_DONE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DISP;
        end
        S_DISP: begin
          if (stat_i.op_restart) begin
            resp_q <= ST_DONE;
            state_q <= S_RESP;
          end else if (stat_i.op_push) begin
            if (stat_i.drop) begin
              resp_q <= ST_DROP;
              state_q <= S_RESP;
            end else if (stat_i.close_now) begin
              ret_build_q <= 1'b0;
              state_q <= S_INS_I;
            end else begin
              resp_q <= ST_DONE;
              state_q <= S_RESP;
            end
          end else if (stat_i.op_pull) begin
            if (stat_i.draining) begin
              state_q <= S_P_START;
            end else if (stat_i.open_nonempty) begin
              ret_build_q <= 1'b1;
              state_q <= S_INS_I;
            end else begin
              state_q <= S_B_INIT;
            end
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_INS_I:   state_q <= stat_i.i_done ? S_CLOSE : S_INS_X;
        S_INS_X:   state_q <= S_INS_CHK;
        S_INS_CHK: state_q <= stat_i.j_at_open ? S_INS_I : S_INS_CMP;
        S_INS_CMP: state_q <= stat_i.key_lt_store ? S_INS_CHK : S_INS_I;
        S_CLOSE: begin
          if (ret_build_q) begin
            state_q <= S_B_INIT;
          end else begin
            resp_q <= ST_DONE;
            state_q <= S_RESP;
          end
        end
        S_B_INIT:  state_q <= S_B_RUN;
        S_B_RUN:   state_q <= stat_i.runs_done ? S_P_START : S_B_TAB;
        S_B_TAB:   state_q <= S_B_VAL;
        S_B_VAL:   state_q <= S_SU;
        S_SU:      state_q <= stat_i.k_zero ? S_B_RUN : S_SU_CMP;
        S_SU_CMP:  state_q <= stat_i.key_lt_heap ? S_SU : S_B_RUN;
        S_P_START: begin
          if (stat_i.hsize_zero) begin
            resp_q <= ST_EMPTY;
            state_q <= S_RESP;
          end else begin
            state_q <= S_P_TOP;
          end
        end
        S_P_TOP:   state_q <= S_P_TAB;
        S_P_TAB:   state_q <= stat_i.run_more ? S_P_NEW : S_P_LAST;
        S_P_NEW:   state_q <= S_SD;
        S_P_LAST:  state_q <= S_SD;
        S_SD: begin
          if (stat_i.l_in) begin
            state_q <= S_SD_L;
          end else begin
            resp_q <= ST_PULLED;
            state_q <= S_RESP;
          end
        end
        S_SD_L:    state_q <= stat_i.r_in ? S_SD_R : S_SD_C;
        S_SD_R:    state_q <= S_SD_C;
        S_SD_C: begin
          if (stat_i.child_lt_key) begin
            state_q <= S_SD;
          end else begin
            resp_q <= ST_PULLED;
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (stat_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/external_merge_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// external_merge_sorter_unit: k-way merge sorter with heap merge
// Stores pushed values, sorts them into runs and merges them on pulls.
//
//   channel  direction  handshake                   beat
//   in       input      in_valid_i / in_stall_o     in_beat_t
//   out      output     out_valid_o / out_stall_i   out_beat_t
//   cfg      input      cfg_valid_i / cfg_ready_o   run_length
//
// A push that fills a run adds an insertion sort through the store memory,
// which moves larger values up one place until each key's place is found.
// The first pull sorts the open run, if it holds values, and builds the heap
// with one sift-up per run; each pull then pops the heap top, refills it from
// the same run or from the last heap entry and sifts it down, or answers
// empty when nothing is left. Reset needs no clearing pass. A result waits
// in the output register under out_stall_i; the next beat is taken meanwhile
// and holds in S_RESP only until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module external_merge_sorter_unit #(
  parameter int STORE_DEPTH = ems_pkg::STORE_DEPTH_DEF,
  parameter int MAX_RUNS    = ems_pkg::MAX_RUNS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire ems_pkg::in_beat_t         in_beat_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output ems_pkg::out_beat_t             out_beat_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [ems_pkg::CFG_W-1:0] cfg_data_i
);
  import ems_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ems_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ems_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_RUNS    (MAX_RUNS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_beat_i   (in_beat_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire
